// ===== sv/cba_pkg.sv =====
package cba_pkg;

    // default sizes of the bitmap
    localparam int unsigned MAX_CLUSTERS_DEF = 65536;
    localparam int unsigned WORD_BITS_DEF    = 32;

    // field widths
    localparam int unsigned OP_W  = 3;
    localparam int unsigned CL_W  = 16;
    localparam int unsigned ST_W  = 2;
    localparam int unsigned CNT_FIELD_W = 17;

    // cluster count register after reset
    localparam logic [CNT_FIELD_W-1:0] CLUSTER_COUNT_RST = 17'd65536;

    // operation codes
    localparam logic [OP_W-1:0] OP_FORMAT    = 3'd0;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK_USED = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_MARK = 3'd4;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;    // write one zero word of the clearing sweep
        logic fmt_start;   // load free count from the cluster count
        logic scan_start;  // restart the word scan at word zero
        logic scan_step;   // read next word of the scan
        logic find_hit;    // take the found cluster as result
        logic use_mark;    // mark polarity: set the bit (used) when high
        logic res_fail;    // result: no free cluster
        logic res_range;   // result: index out of range
        logic res_none;    // result: no-op with current count
        logic mark_cap;    // capture the request cluster index
        logic mark_div;    // split cluster index, word part
        logic mark_rd;     // read the word of the cluster
        logic mark_wr;     // write back the changed word
        logic out_load;    // move result into the output register
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic count_zero;  // free count is zero
        logic in_range;    // request cluster is below the cluster count
        logic clr_last;    // sweep is at the last word
        logic hit;         // checked word holds a free cluster
        logic scan_end;    // checked word was the last one to look at
    } t_sts;

endpackage

// ===== sv/cluster_bitmap_allocator.sv =====
// Cluster bitmap allocator: keeps one usage bit per cluster (1 = in use) in a
// single-port-read block RAM of MAX_CLUSTERS/WORD_BITS words, plus a saturating
// free count. Requests are handled one at a time. After reset, and on every
// format, the block sweeps the bitmap to zero, one word per cycle, and holds
// ready low for the whole sweep; a format returns its result after the sweep
// ends. A find (or find-and-mark) reads the bitmap words in order, one RAM read
// per cycle, up to the first word with a free cluster below the cluster count;
// it answers with no free cluster, without reading, when the free count is
// zero. Mark used and mark free pass through index split, RAM read, write back
// and result; out-of-range marks and undefined operations go straight to the
// result. A finished result sits in the output register, and the next request
// is accepted while it waits.
// A cluster_count write bounds marks and finds at once; the free count takes it
// up on the next format.
module cluster_bitmap_allocator #(
    parameter int unsigned MAX_CLUSTERS = cba_pkg::MAX_CLUSTERS_DEF,
    parameter int unsigned WORD_BITS    = cba_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cba_pkg::CNT_FIELD_W-1:0]   i_cfg_cluster_count,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [cba_pkg::OP_W-1:0]          i_operation,
    input  logic [cba_pkg::CL_W-1:0]          i_cluster,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [cba_pkg::ST_W-1:0]          o_status,
    output logic [cba_pkg::CL_W-1:0]          o_found_cluster,
    output logic [cba_pkg::CNT_FIELD_W-1:0]   o_free_left
);
    import cba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    cba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cba_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .WORD_BITS    (WORD_BITS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_valid && o_cfg_ready),
        .i_cfg_cluster_count (i_cfg_cluster_count),
        .i_cluster           (i_cluster),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_status            (o_status),
        .o_found_cluster     (o_found_cluster),
        .o_free_left         (o_free_left)
    );

endmodule

// ===== sv/cba_ram.sv =====
module cba_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cba_ctrl.sv =====
module cba_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [cba_pkg::OP_W-1:0]    i_operation,
    output logic                        o_valid,
    input  logic                        i_ready,
    input  cba_pkg::t_sts               i_sts,
    output cba_pkg::t_cmd               o_cmd
);
    import cba_pkg::*;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_RD,
        S_WR,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_fmt_clr, n_fmt_clr;
    logic   r_use_mark, n_use_mark;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_fmt_clr   = r_fmt_clr;
        n_use_mark  = r_use_mark;
        n_out_valid = r_out_valid & ~i_ready;
        cmd          = '0;
        cmd.use_mark = r_use_mark;
        unique case (r_state)
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_fmt_clr ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_operation)
                        OP_FORMAT: begin
                            cmd.fmt_start = 1'b1;
                            n_fmt_clr     = 1'b1;
                            n_state       = S_CLR;
                        end
                        OP_FIND, OP_FIND_MARK: begin
                            n_use_mark = (i_operation == OP_FIND_MARK);
                            if (i_sts.count_zero) begin
                                cmd.res_fail = 1'b1;
                                n_state      = S_RESP;
                            end else begin
                                cmd.scan_start = 1'b1;
                                n_state        = S_SCAN;
                            end
                        end
                        OP_MARK_USED, OP_MARK_FREE: begin
                            n_use_mark = (i_operation == OP_MARK_USED);
                            if (i_sts.in_range) begin
                                cmd.mark_cap = 1'b1;
                                n_state      = S_DIV;
                            end else begin
                                cmd.res_range = 1'b1;
                                n_state       = S_RESP;
                            end
                        end
                        default: begin
                            cmd.res_none = 1'b1;
                            n_state      = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    cmd.find_hit = 1'b1;
                    n_state      = S_RESP;
                end else if (i_sts.scan_end) begin
                    cmd.res_fail = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DIV: begin
                cmd.mark_div = 1'b1;
                n_state      = S_RD;
            end
            S_RD: begin
                cmd.mark_rd = 1'b1;
                n_state     = S_WR;
            end
            S_WR: begin
                cmd.mark_wr = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_fmt_clr   <= 1'b0;
            r_use_mark  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fmt_clr   <= n_fmt_clr;
            r_use_mark  <= n_use_mark;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

endmodule

// ===== sv/cba_datapath.sv =====
module cba_datapath #(
    parameter int unsigned MAX_CLUSTERS = cba_pkg::MAX_CLUSTERS_DEF,
    parameter int unsigned WORD_BITS    = cba_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cba_pkg::CNT_FIELD_W-1:0]   i_cfg_cluster_count,
    input  logic [cba_pkg::CL_W-1:0]          i_cluster,
    input  cba_pkg::t_cmd                     i_cmd,
    output cba_pkg::t_sts                     o_sts,
    output logic [cba_pkg::ST_W-1:0]          o_status,
    output logic [cba_pkg::CL_W-1:0]          o_found_cluster,
    output logic [cba_pkg::CNT_FIELD_W-1:0]   o_free_left
);
    import cba_pkg::*;

    localparam int unsigned MAP_WORDS = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned BIT_W     = $clog2(WORD_BITS);
    localparam int unsigned CNT_W     = $clog2(MAX_CLUSTERS + 1);
    localparam int unsigned LIM_W     = (CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W;
    localparam int unsigned BASE_W    = LIM_W + 1;
    localparam int unsigned DIV_SH    = CL_W + 7;
    localparam int unsigned MULT_W    = DIV_SH - 2;
    localparam int unsigned DIV_MULT  = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned PROD_W    = CL_W + MULT_W;
    localparam int unsigned Q_W       = PROD_W - DIV_SH;
    localparam int unsigned REM_W     = CL_W + 7;
    localparam int unsigned COUNT_RST =
        (CLUSTER_COUNT_RST > MAX_CLUSTERS) ? MAX_CLUSTERS : CLUSTER_COUNT_RST;

    // configuration and counters
    logic [CNT_FIELD_W-1:0] r_cluster_count;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [WORD_W-1:0]      r_clr_addr;
    logic [WORD_W-1:0]      r_scan_addr;
    logic [WORD_W-1:0]      r_chk_addr;
    logic                   r_chk_valid;

    // mark path registers
    logic [CL_W-1:0]        r_cl;
    logic [Q_W-1:0]         r_q;
    logic [BIT_W-1:0]       r_bit;
    logic [WORD_W-1:0]      r_waddr;

    // result staging and output registers
    logic [ST_W-1:0]        r_res_status, n_res_status;
    logic [CL_W-1:0]        r_res_found, n_res_found;
    logic [CNT_W-1:0]       r_res_free, n_res_free;
    logic [ST_W-1:0]        r_out_status;
    logic [CL_W-1:0]        r_out_found;
    logic [CNT_W-1:0]       r_out_free;

    // memory ports
    logic                   mem_we;
    logic [WORD_W-1:0]      mem_waddr;
    logic [WORD_BITS-1:0]   mem_wdata;
    logic                   mem_re;
    logic [WORD_W-1:0]      mem_raddr;
    logic [WORD_BITS-1:0]   mem_rdata;

    // derived values
    logic [LIM_W-1:0]       eff_count;
    logic [BASE_W-1:0]      base;
    logic [BASE_W-1:0]      rem;
    logic                   rem_neg;
    logic                   word_full_range;
    logic                   word_last;
    logic [WORD_BITS-1:0]   limit_mask;
    logic [WORD_BITS-1:0]   cand;
    logic [BIT_W-1:0]       hit_pos;
    logic                   hit;
    logic [PROD_W-1:0]      div_prod;
    logic [REM_W-1:0]       q_times_w;
    logic [WORD_BITS-1:0]   mark_onehot;
    logic [WORD_BITS-1:0]   hit_onehot;
    logic                   mark_bit_now;
    logic                   mark_changed;
    logic [WORD_BITS-1:0]   mark_word;
    logic [CNT_W-1:0]       count_dec;
    logic [CNT_W-1:0]       count_inc;

    cba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (WORD_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // effective cluster count, clamped to the map size
    always_comb begin
        if (LIM_W'(r_cluster_count) > LIM_W'(MAX_CLUSTERS)) begin
            eff_count = LIM_W'(MAX_CLUSTERS);
        end else begin
            eff_count = LIM_W'(r_cluster_count);
        end
    end

    // saturating count steps
    assign count_dec = (r_count == '0) ? r_count : r_count - CNT_W'(1);
    assign count_inc = (r_count == CNT_W'(MAX_CLUSTERS)) ? r_count : r_count + CNT_W'(1);

    // bounds of the word under check
    assign base    = BASE_W'(r_chk_addr * WORD_BITS);
    assign rem     = {1'b0, eff_count} - base;
    assign rem_neg = rem[BASE_W-1];
    assign word_full_range = !rem_neg && (rem >= BASE_W'(WORD_BITS));
    assign word_last = rem_neg || (rem <= BASE_W'(WORD_BITS))
                       || (r_chk_addr == WORD_W'(MAP_WORDS - 1));

    // bits of the word that lie below the cluster count
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            limit_mask[b] = word_full_range || (!rem_neg && (BASE_W'(b) < rem));
        end
    end

    assign cand = ~mem_rdata & limit_mask;
    assign hit  = r_chk_valid && (cand != '0);

    // lowest free bit of the checked word
    always_comb begin
        hit_pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                hit_pos = BIT_W'(b);
            end
        end
    end

    assign hit_onehot = WORD_BITS'(1) << hit_pos;

    // cluster index split: word by reciprocal multiply, bit by remainder
    assign div_prod  = PROD_W'(r_cl) * PROD_W'(DIV_MULT);
    assign q_times_w = REM_W'(r_q * WORD_BITS);

    // mark update of the read word
    assign mark_onehot  = WORD_BITS'(1) << r_bit;
    assign mark_bit_now = mem_rdata[r_bit];
    assign mark_changed = i_cmd.use_mark ? !mark_bit_now : mark_bit_now;
    assign mark_word    = i_cmd.use_mark ? (mem_rdata | mark_onehot)
                                         : (mem_rdata & ~mark_onehot);

    // memory write mux
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        priority if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.mark_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_waddr;
            mem_wdata = mark_word;
        end else if (i_cmd.find_hit && i_cmd.use_mark) begin
            mem_we    = 1'b1;
            mem_waddr = r_chk_addr;
            mem_wdata = mem_rdata | hit_onehot;
        end else begin
            mem_we = 1'b0;
        end
    end

    // memory read mux
    assign mem_re    = i_cmd.scan_step || i_cmd.mark_rd;
    assign mem_raddr = i_cmd.mark_rd ? WORD_W'(r_q) : r_scan_addr;

    // free count update
    always_comb begin
        n_count = r_count;
        priority if (i_cmd.fmt_start) begin
            n_count = CNT_W'(eff_count);
        end else if (i_cmd.mark_wr && mark_changed) begin
            n_count = i_cmd.use_mark ? count_dec : count_inc;
        end else if (i_cmd.find_hit && i_cmd.use_mark) begin
            n_count = count_dec;
        end else begin
            n_count = r_count;
        end
    end

    // result staging
    always_comb begin
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_free   = r_res_free;
        priority if (i_cmd.find_hit) begin
            n_res_status = ST_OK;
            n_res_found  = CL_W'(base + BASE_W'(hit_pos));
            n_res_free   = n_count;
        end else if (i_cmd.res_fail) begin
            n_res_status = ST_NO_SPACE;
            n_res_found  = '0;
            n_res_free   = r_count;
        end else if (i_cmd.res_range) begin
            n_res_status = ST_RANGE;
            n_res_found  = '0;
            n_res_free   = r_count;
        end else if (i_cmd.fmt_start || i_cmd.mark_wr || i_cmd.res_none) begin
            n_res_status = ST_OK;
            n_res_found  = '0;
            n_res_free   = n_count;
        end else begin
            n_res_status = r_res_status;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CLUSTER_COUNT_RST;
            r_count         <= CNT_W'(COUNT_RST);
            r_clr_addr      <= '0;
            r_chk_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cluster_count <= i_cfg_cluster_count;
            end
            r_count <= n_count;
            if (i_cmd.clr_step) begin
                if (r_clr_addr == WORD_W'(MAP_WORDS - 1)) begin
                    r_clr_addr <= '0;
                end else begin
                    r_clr_addr <= r_clr_addr + WORD_W'(1);
                end
            end
            if (i_cmd.scan_start) begin
                r_chk_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + WORD_W'(1);
            r_chk_addr  <= r_scan_addr;
        end
        if (i_cmd.mark_cap) begin
            r_cl <= i_cluster;
        end
        if (i_cmd.mark_div) begin
            r_q <= div_prod[PROD_W-1:DIV_SH];
        end
        if (i_cmd.mark_rd) begin
            r_bit   <= BIT_W'({7'd0, r_cl} - q_times_w);
            r_waddr <= WORD_W'(r_q);
        end
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_free   <= n_res_free;
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_free   <= r_res_free;
        end
    end

    // status to the controller
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.in_range   = (LIM_W'(i_cluster) < eff_count);
    assign o_sts.clr_last   = (r_clr_addr == WORD_W'(MAP_WORDS - 1));
    assign o_sts.hit        = hit;
    assign o_sts.scan_end   = r_chk_valid && !hit && word_last;

    assign o_status        = r_out_status;
    assign o_found_cluster = r_out_found;
    assign o_free_left     = CNT_FIELD_W'(r_out_free);

endmodule
